// ===== src/lpg_pkg.sv =====
// Shared types, constants and helpers for the LED pattern generator.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package lpg_pkg;

  localparam int unsigned LVL_W    = 8;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PER_W    = 16;
  localparam int unsigned ELAP_W   = 10;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned PH_W     = 8;
  localparam int unsigned DVD_W    = CNT_W + PH_W;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = PER_W;
  localparam int unsigned SQ_W     = 15;

  localparam logic [MODE_W-1:0] MODE_SOLID      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK_SLOW = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK_FAST = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PULSE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;

  localparam logic [PER_W-1:0] DEFAULT_PERIOD = 16'd1000;
  localparam logic [PER_W-1:0] FAST_PERIOD    = 16'd500;
  localparam logic [LVL_W-1:0] FULL_LEVEL     = 8'hFF;
  localparam logic [LVL_W-1:0] RESET_BRIGHT   = 8'hFF;
  localparam logic [PH_W:0]    FOLD_POINT     = 9'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CURVE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [PER_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PER_W-1:0]  remainder;
    logic [PH_W-1:0]   quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [LVL_W-1:0]  a;
    logic [LVL_W-1:0]  b;
  } scl_req_t;

  typedef struct packed {
    logic              done;
    logic [LVL_W-1:0]  value;
  } scl_rsp_t;

  // floor(x / 255) for x up to 255 * 255: reciprocal estimate plus one fix-up
  function automatic logic [LVL_W-1:0] div255(input logic [2*LVL_W-1:0] x);
    logic [2*LVL_W:0]   sum;
    logic [LVL_W:0]     q0;
    logic [2*LVL_W+1:0] prod;
    logic [2*LVL_W+1:0] rem;
    logic [LVL_W:0]     q;
    sum  = {1'b0, x} + {9'd0, x[2*LVL_W-1:LVL_W]};
    q0   = sum[2*LVL_W:LVL_W];
    prod = {q0, 8'd0} - {9'd0, q0};
    rem  = {2'b00, x} - prod;
    q    = (rem >= 18'd255) ? q0 + 9'd1 : q0;
    return q[LVL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/lpg_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by blink and pulse.
// Depends on lpg_pkg for widths and request/response structs.
`default_nettype none

module lpg_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpg_pkg::div_req_t req,
  output lpg_pkg::div_rsp_t      rsp
);

  logic [lpg_pkg::DVD_W-1:0]  dvd_r;
  logic [lpg_pkg::PER_W-1:0]  dvs_r;
  logic [lpg_pkg::PER_W-1:0]  rem_r;
  logic [lpg_pkg::PH_W-1:0]   quo_r;
  logic [lpg_pkg::STEP_W-1:0] cnt_r;
  logic                       done_r;

  logic [lpg_pkg::PER_W:0]    trial;
  logic [lpg_pkg::PER_W:0]    diff;
  logic                       qbit;

  assign trial = {rem_r, dvd_r[lpg_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= lpg_pkg::STEP_W'(lpg_pkg::DIV_STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == lpg_pkg::STEP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[lpg_pkg::DVD_W-2:0], 1'b0};
      rem_r <= qbit ? diff[lpg_pkg::PER_W-1:0] : trial[lpg_pkg::PER_W-1:0];
      quo_r <= {quo_r[lpg_pkg::PH_W-2:0], qbit};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;
  assign rsp.quotient  = quo_r;

endmodule

`default_nettype wire

// ===== src/lpg_scale.sv =====
// Shared level scaler: a * b / 255, product registered, then divided by 255.
// Depends on lpg_pkg for structs and the div255 helper.
`default_nettype none

module lpg_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpg_pkg::scl_req_t req,
  output lpg_pkg::scl_rsp_t      rsp
);

  logic [2*lpg_pkg::LVL_W-1:0] prod_r;
  logic                        prod_vld_r;
  logic [lpg_pkg::LVL_W-1:0]   value_r;
  logic                        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      prod_vld_r <= req.start;
      done_r     <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= req.a * req.b;
    value_r <= lpg_pkg::div255(prod_r);
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

`default_nettype wire

// ===== src/led_pattern_generator.sv =====
// LED pattern generator top: config registers, ms counter, sequencer.
// Depends on lpg_pkg, lpg_div and lpg_scale.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------
//  in      | in_elapsed_ms[9:0]                      | in_valid/in_ready
//  out     | out_red_out, out_green_out, out_blue_out| out_valid/out_ready
//  cfg     | cfg_index[2:0], cfg_data[15:0]          | cfg_we, no wait
//
// Each beat runs the bit-serial divider, the curve step and six passes through
// the shared 8x8 scaler (pattern level, then brightness), then the handoff to
// the output register.
// rst_n is synchronous; it restores register defaults and clears the counter.
// A result waiting on out_ready does not block the next input beat; the block
// holds at the end of that beat until the output register frees.
`default_nettype none

module led_pattern_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lpg_pkg::ELAP_W-1:0]      in_elapsed_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lpg_pkg::LVL_W-1:0]            out_red_out,
  output logic [lpg_pkg::LVL_W-1:0]            out_green_out,
  output logic [lpg_pkg::LVL_W-1:0]            out_blue_out,
  input  wire logic                            cfg_we,
  input  wire logic [lpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpg_pkg::CFG_DAT_W-1:0]   cfg_data
);

  logic [lpg_pkg::LVL_W-1:0]  red_r, green_r, blue_r, bright_r;
  logic [lpg_pkg::MODE_W-1:0] mode_r;
  logic [lpg_pkg::PER_W-1:0]  period_r;
  logic [lpg_pkg::CNT_W-1:0]  counter_r;

  lpg_pkg::state_t state_r, state_nxt;

  logic [lpg_pkg::SQ_W-1:0]   sq_r;
  logic [lpg_pkg::LVL_W-1:0]  inten_r;
  logic [lpg_pkg::LVL_W-1:0]  col_r [3];
  logic [1:0]                 chan_r;
  logic                       pass_r;
  logic                       out_valid_r;
  logic [lpg_pkg::LVL_W-1:0]  out_red_r, out_green_r, out_blue_r;

  lpg_pkg::div_req_t div_req;
  lpg_pkg::div_rsp_t div_rsp;
  lpg_pkg::scl_req_t scl_req;
  lpg_pkg::scl_rsp_t scl_rsp;

  logic                       accept;
  logic                       load_out;
  logic                       is_blink;
  logic                       is_pulse;
  logic [lpg_pkg::PER_W-1:0]  per_base;
  logic [lpg_pkg::PER_W-1:0]  per_eff;
  logic [lpg_pkg::CNT_W-1:0]  cnt_sum;
  logic [lpg_pkg::PH_W:0]     fold_x;
  logic [lpg_pkg::SQ_W+7:0]   curve_full;
  logic                       lit;

  assign is_blink = (mode_r == lpg_pkg::MODE_BLINK_SLOW) ||
                    (mode_r == lpg_pkg::MODE_BLINK_FAST);
  assign is_pulse = (mode_r == lpg_pkg::MODE_PULSE);
  assign per_base = (period_r == '0) ? lpg_pkg::DEFAULT_PERIOD : period_r;
  assign per_eff  = ((mode_r == lpg_pkg::MODE_BLINK_FAST) &&
                     (per_base == lpg_pkg::DEFAULT_PERIOD)) ? lpg_pkg::FAST_PERIOD
                                                            : per_base;
  assign cnt_sum  = counter_r + lpg_pkg::CNT_W'(in_elapsed_ms);

  assign fold_x     = ({1'b0, div_rsp.quotient} > lpg_pkg::FOLD_POINT)
                      ? 9'd256 - {1'b0, div_rsp.quotient}
                      : {1'b0, div_rsp.quotient};
  assign curve_full = {sq_r, 8'd0} - {8'd0, sq_r};
  assign lit        = (div_rsp.remainder < (per_eff >> 1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
      bright_r <= lpg_pkg::RESET_BRIGHT;
      mode_r   <= lpg_pkg::MODE_SOLID;
      period_r <= lpg_pkg::DEFAULT_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpg_pkg::REG_RED:    red_r    <= cfg_data[lpg_pkg::LVL_W-1:0];
        lpg_pkg::REG_GREEN:  green_r  <= cfg_data[lpg_pkg::LVL_W-1:0];
        lpg_pkg::REG_BLUE:   blue_r   <= cfg_data[lpg_pkg::LVL_W-1:0];
        lpg_pkg::REG_BRIGHT: bright_r <= cfg_data[lpg_pkg::LVL_W-1:0];
        lpg_pkg::REG_MODE:   mode_r   <= cfg_data[lpg_pkg::MODE_W-1:0];
        lpg_pkg::REG_PERIOD: period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Millisecond counter, advanced as the beat is taken in blink and pulse modes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (accept) begin
      if (is_blink) begin
        counter_r <= cnt_sum;
      end else if (is_pulse) begin
        counter_r <= (cnt_sum >= lpg_pkg::CNT_W'(per_eff)) ? '0 : cnt_sum;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpg_pkg::ST_IDLE:  if (in_valid) state_nxt = lpg_pkg::ST_DIV;
      lpg_pkg::ST_DIV:   if (div_rsp.done) state_nxt = lpg_pkg::ST_SQ;
      lpg_pkg::ST_SQ:    state_nxt = lpg_pkg::ST_CURVE;
      lpg_pkg::ST_CURVE: state_nxt = lpg_pkg::ST_ISSUE;
      lpg_pkg::ST_ISSUE: state_nxt = lpg_pkg::ST_WAIT;
      lpg_pkg::ST_WAIT: begin
        if (scl_rsp.done) begin
          state_nxt = (pass_r && chan_r == 2'd2) ? lpg_pkg::ST_DONE : lpg_pkg::ST_ISSUE;
        end
      end
      lpg_pkg::ST_DONE:  if (!out_valid_r || out_ready) state_nxt = lpg_pkg::ST_IDLE;
      default:           state_nxt = lpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state_r == lpg_pkg::ST_IDLE);
    accept           = in_ready && in_valid;
    load_out         = (state_r == lpg_pkg::ST_DONE) && (!out_valid_r || out_ready);
    div_req.start    = accept;
    div_req.dividend = is_pulse ? {counter_r, 8'd0} : {8'd0, counter_r};
    div_req.divisor  = per_eff;
    scl_req.start    = (state_r == lpg_pkg::ST_ISSUE);
    scl_req.a        = col_r[chan_r];
    scl_req.b        = pass_r ? bright_r : inten_r;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r[0] <= red_r;
      col_r[1] <= green_r;
      col_r[2] <= blue_r;
      chan_r   <= '0;
      pass_r   <= 1'b0;
    end else if (state_r == lpg_pkg::ST_WAIT && scl_rsp.done) begin
      col_r[chan_r] <= scl_rsp.value;
      if (chan_r == 2'd2) begin
        chan_r <= '0;
        pass_r <= 1'b1;
      end else begin
        chan_r <= chan_r + 2'd1;
      end
    end
    if (state_r == lpg_pkg::ST_SQ) begin
      sq_r <= lpg_pkg::SQ_W'(fold_x[lpg_pkg::PH_W-1:0] * fold_x[lpg_pkg::PH_W-1:0]);
    end
    if (state_r == lpg_pkg::ST_CURVE) begin
      priority if (mode_r == lpg_pkg::MODE_SOLID) begin
        inten_r <= lpg_pkg::FULL_LEVEL;
      end else if (is_blink) begin
        inten_r <= lit ? lpg_pkg::FULL_LEVEL : '0;
      end else if (is_pulse) begin
        inten_r <= curve_full[lpg_pkg::SQ_W+6:lpg_pkg::SQ_W-1];
      end else begin
        inten_r <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red_r   <= col_r[0];
      out_green_r <= col_r[1];
      out_blue_r  <= col_r[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

  lpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lpg_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scl_req),
    .rsp   (scl_rsp)
  );

endmodule

`default_nettype wire
